// File: hdl/fsha_pkg.sv
// Shared types and constants for the fit-strategy heap allocator.
package fsha_pkg;
  localparam int unsigned HandleCount = 64;
  localparam int unsigned FreeSlots   = 128;
  localparam int unsigned AddrBits    = 16;
  localparam int unsigned HandleBits  = $clog2(HandleCount);
  localparam int unsigned SlotBits    = $clog2(FreeSlots);
  localparam int unsigned SizeBits    = AddrBits + 1;
  localparam int unsigned CfgBits     = 17;

  localparam logic [0:0] CfgIdxMode  = 1'b0;
  localparam logic [0:0] CfgIdxWords = 1'b1;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StOom     = 3'd1;
  localparam logic [2:0] StInvalid = 3'd2;
  localparam logic [2:0] StDouble  = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  localparam logic [1:0] ModeBest  = 2'd1;
  localparam logic [1:0] ModeWorst = 2'd2;

  localparam logic KindAlloc = 1'b0;

  typedef enum logic [1:0] {
    H_ABSENT = 2'd0,
    H_LIVE   = 2'd1,
    H_FREED  = 2'd2
  } hstat_e;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] last;
  } extent_t;

  // Free-list write port from the controller.
  typedef struct packed {
    logic                en;
    logic [SlotBits-1:0] addr;
    logic                valid;
    extent_t             ext;
  } fl_wr_t;
endpackage

// File: hdl/fsha_free_list.sv
// Free-extent memory with per-slot valid flags and sweep read port.
module fsha_free_list (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic [fsha_pkg::AddrBits-1:0] init_last_i,
  input  logic                    init_nonempty_i,
  input  logic [fsha_pkg::SlotBits-1:0] rd_addr_i,
  output fsha_pkg::extent_t       rd_ext_o,
  output logic                    rd_valid_o,
  input  fsha_pkg::fl_wr_t        wr_i
);
  import fsha_pkg::*;

  extent_t           mem_q [FreeSlots];
  logic [FreeSlots-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      mem_q[0] <= '{start: '0, last: init_last_i};
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.ext;
    end
    rd_ext_o <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= {{(FreeSlots-1){1'b0}}, 1'b1};
      rd_valid_o <= 1'b0;
    end else begin
      if (init_i) begin
        valid_q <= {{(FreeSlots-1){1'b0}}, init_nonempty_i};
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= wr_i.valid;
      end
      rd_valid_o <= valid_q[rd_addr_i];
    end
  end

  // Reset contents of slot 0 follow from init pulse asserted out of reset.
`ifndef ASSERT_OFF
  a_no_wr_on_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_i |-> !wr_i.en) else $error("free list write during init");
  a_init_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_i |=> valid_q[0] == $past(init_nonempty_i)) else $error("init slot0");
  a_wr_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.en && !init_i) |=> valid_q[$past(wr_i.addr)] == $past(wr_i.valid))
    else $error("valid write lost");
`endif
endmodule

// File: hdl/fit_strategy_heap_allocator_unit.sv
// Top level: heap allocator with first, best and worst fit placement.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------------
//  request   | in        | req_valid/ready    | kind, handle_id, request_size
//  response  | out       | rsp_valid/ready    | status, block_start, leak_valid/start/end
//  config    | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One transaction at a time. An allocate sweeps all FreeSlots slots of the
// free-list memory (one read per cycle while no config write holds the sweep,
// registered read port); a free also sweeps all slots, for the lowest empty slot.
// After reset (and after a memory_words write) the S_INIT state reloads slot 0.
// The response sits in an output register; a new request is taken once it
// has been handed over. Handle state lives in flip-flops (status) and a
// small memory (extent), read when the request is accepted.
module fit_strategy_heap_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        kind_i,
  input  logic [5:0]  handle_id_i,
  input  logic [16:0] request_size_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] block_start_o,
  output logic        leak_valid_o,
  output logic [15:0] leak_start_o,
  output logic [15:0] leak_end_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);
  import fsha_pkg::*;

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_SCAN, S_DONE} state_e;

  state_e                state_q;
  logic [1:0]            mode_q;
  logic [SizeBits-1:0]   words_q;
  logic                  kind_q;
  logic [HandleBits-1:0] hid_q;
  logic [SizeBits-1:0]   size_q;
  logic [SlotBits:0]     cnt_q;     // issued read address, wide to count to FreeSlots
  logic [SlotBits-1:0]   raddr_q;   // address of data now on the read port
  logic                  rvld_q;
  logic                  found_q;
  logic [SlotBits-1:0]   best_q;
  logic [AddrBits-1:0]   bstart_q;
  logic [SizeBits-1:0]   blen_q;
  logic [AddrBits-1:0]   blast_q;
  hstat_e                hstat_q [HandleCount];
  extent_t               hmem_q [HandleCount];
  extent_t               hext_q;
  logic                  rsp_valid_q;

  extent_t               rd_ext;
  logic                  rd_valid;
  fl_wr_t                wr;
  logic                  init;
  logic [SizeBits-1:0]   sat_words;
  logic [SizeBits-1:0]   len;
  logic                  fits;
  logic                  take;
  logic                  req_acc;

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign req_acc     = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign init        = (state_q == S_INIT);
  assign sat_words   = words_q[SizeBits-1] ? {1'b1, {AddrBits{1'b0}}} : words_q;

  fsha_free_list u_free_list (
    .clk_i,
    .rst_ni,
    .init_i          (init),
    .init_last_i     (sat_words[AddrBits-1:0] - 1'b1),
    .init_nonempty_i (sat_words != '0),
    .rd_addr_i       (cnt_q[SlotBits-1:0]),
    .rd_ext_o        (rd_ext),
    .rd_valid_o      (rd_valid),
    .wr_i            (wr)
  );

  assign len  = {1'b0, rd_ext.last} - {1'b0, rd_ext.start} + 1'b1;
  assign fits = rd_valid && (len >= size_q);

  always_comb begin
    take = 1'b0;
    if (kind_q == KindAlloc) begin
      if (fits) begin
        if (!found_q) take = 1'b1;
        else begin
          unique case (mode_q)
            ModeBest:  take = (len < blen_q) ||
                              (len == blen_q && rd_ext.start < bstart_q);
            ModeWorst: take = (len > blen_q) ||
                              (len == blen_q && rd_ext.start < bstart_q);
            default:   take = rd_ext.start < bstart_q;
          endcase
        end
      end
    end else begin
      take = !rd_valid && !found_q;
    end
  end

  // Commit write to the free list on leaving the sweep.
  always_comb begin
    wr = '0;
    if (state_q == S_DONE && found_q) begin
      if (kind_q == KindAlloc) begin
        if (size_q != '0) begin
          wr.en    = 1'b1;
          wr.addr  = best_q;
          wr.valid = blen_q > size_q;
          wr.ext   = '{start: bstart_q + size_q[AddrBits-1:0], last: blast_q};
        end
      end else if (hstat_q[hid_q] == H_LIVE) begin
        wr.en    = 1'b1;
        wr.addr  = best_q;
        wr.valid = 1'b1;
        wr.ext   = hext_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) hext_q <= hmem_q[handle_id_i];
    if (state_q == S_DONE && kind_q == KindAlloc && found_q && size_q != '0) begin
      hmem_q[hid_q] <= '{start: bstart_q,
                         last: bstart_q + size_q[AddrBits-1:0] - 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      mode_q        <= '0;
      words_q       <= {1'b1, {AddrBits{1'b0}}};
      kind_q        <= 1'b0;
      hid_q         <= '0;
      size_q        <= '0;
      cnt_q         <= '0;
      raddr_q       <= '0;
      rvld_q        <= 1'b0;
      found_q       <= 1'b0;
      best_q        <= '0;
      bstart_q      <= '0;
      blen_q        <= '0;
      blast_q       <= '0;
      rsp_valid_q   <= 1'b0;
      status_o      <= '0;
      block_start_o <= '0;
      leak_valid_o  <= 1'b0;
      leak_start_o  <= '0;
      leak_end_o    <= '0;
      for (int i = 0; i < HandleCount; i++) hstat_q[i] <= H_ABSENT;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgIdxMode: mode_q <= cfg_data_i[1:0];
          CfgIdxWords: begin
            words_q <= cfg_data_i;
            state_q <= S_INIT;
            for (int i = 0; i < HandleCount; i++) hstat_q[i] <= H_ABSENT;
          end
          default: ;
        endcase
      end else begin
        unique case (state_q)
          S_INIT: state_q <= S_IDLE;
          S_IDLE: begin
            if (req_acc) begin
              kind_q  <= kind_i;
              hid_q   <= handle_id_i;
              size_q  <= request_size_i;
              cnt_q   <= '0;
              rvld_q  <= 1'b0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
          S_SCAN: begin
            raddr_q <= cnt_q[SlotBits-1:0];
            rvld_q  <= cnt_q < (SlotBits+1)'(FreeSlots);
            if (cnt_q < (SlotBits+1)'(FreeSlots)) cnt_q <= cnt_q + 1'b1;
            if (rvld_q && take) begin
              found_q  <= 1'b1;
              best_q   <= raddr_q;
              bstart_q <= rd_ext.start;
              blast_q  <= rd_ext.last;
              blen_q   <= len;
            end
            if (!rvld_q && cnt_q == (SlotBits+1)'(FreeSlots)) state_q <= S_DONE;
          end
          S_DONE: begin
            state_q     <= S_IDLE;
            rsp_valid_q <= 1'b1;
            if (kind_q == KindAlloc) begin
              // a live handle gives up its old extent whatever the outcome
              leak_valid_o <= (hstat_q[hid_q] == H_LIVE);
              leak_start_o <= (hstat_q[hid_q] == H_LIVE) ? hext_q.start : '0;
              leak_end_o   <= (hstat_q[hid_q] == H_LIVE) ? hext_q.last : '0;
              if (!found_q || size_q == '0) begin
                status_o       <= StOom;
                block_start_o  <= '0;
                hstat_q[hid_q] <= H_ABSENT;
              end else begin
                status_o       <= StOk;
                block_start_o  <= bstart_q;
                hstat_q[hid_q] <= H_LIVE;
              end
            end else begin
              block_start_o <= '0;
              leak_valid_o  <= 1'b0;
              leak_start_o  <= '0;
              leak_end_o    <= '0;
              if (hstat_q[hid_q] == H_LIVE) begin
                if (found_q) begin
                  status_o       <= StOk;
                  hstat_q[hid_q] <= H_FREED;
                end else status_o <= StFull;
              end else if (hstat_q[hid_q] == H_FREED) status_o <= StDouble;
              else status_o <= StInvalid;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_o) else $error("second transaction accepted");
  a_rsp_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE)) else $error("stray response");
  a_ok_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !found_q && kind_q == KindAlloc && !cfg_we_i)
    |=> status_o == StOom) else $error("alloc without extent");
`endif
endmodule

// File: tb/fsha_alloc_checker.sv
// Allocator checker: follows the channels, predicts every reply and compares it.
module fsha_alloc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic        kind_i,
  input  logic [5:0]  handle_id_i,
  input  logic [16:0] request_size_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] block_start_i,
  input  logic        leak_valid_i,
  input  logic [15:0] leak_start_i,
  input  logic [15:0] leak_end_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  output int          fails_o,
  output int          pending_o
);
  import fsha_pkg::*;

  typedef struct packed {
    logic [2:0]          status;
    logic [AddrBits-1:0] bstart;
    logic                lv;
    logic [AddrBits-1:0] ls;
    logic [AddrBits-1:0] le;
  } reply_t;

  logic [1:0]          placement;
  logic [AddrBits-1:0] fl_start [FreeSlots];
  logic [AddrBits-1:0] fl_last  [FreeSlots];
  logic                fl_vld   [FreeSlots];
  hstat_e              hs       [HandleCount];
  logic [AddrBits-1:0] h_start  [HandleCount];
  logic [AddrBits-1:0] h_last   [HandleCount];
  reply_t              expected_replies [$];

  assign pending_o = expected_replies.size();

  task automatic init_heap(input logic [16:0] words);
    int unsigned w;
    w = (words > 17'd65536) ? 65536 : words;
    for (int i = 0; i < FreeSlots; i++) begin
      fl_vld[i] = 1'b0; fl_start[i] = '0; fl_last[i] = '0;
    end
    for (int i = 0; i < HandleCount; i++) begin
      hs[i] = H_ABSENT; h_start[i] = '0; h_last[i] = '0;
    end
    if (w != 0) begin
      fl_vld[0]  = 1'b1;
      fl_last[0] = AddrBits'(w - 1);
    end
  endtask

  task automatic predict_allocation(input logic kind, input logic [5:0] h,
                                    input logic [16:0] size, output reply_t r);
    int          slot;
    int unsigned len, best_len, s;
    bit          take;
    r = '0;
    r.status = StOk;
    slot = -1;
    best_len = 0;
    if (kind == KindAlloc) begin
      if (size != 0) begin
        for (int i = 0; i < FreeSlots; i++) begin
          if (fl_vld[i]) begin
            len = 32'(fl_last[i]) - 32'(fl_start[i]) + 1;
            if (len >= size) begin
              if (slot < 0) take = 1'b1;
              else if (placement == ModeBest)
                take = len < best_len || (len == best_len && fl_start[i] < fl_start[slot]);
              else if (placement == ModeWorst)
                take = len > best_len || (len == best_len && fl_start[i] < fl_start[slot]);
              else take = fl_start[i] < fl_start[slot];
              if (take) begin
                slot = i; best_len = len;
              end
            end
          end
        end
      end
      // live handle loses its old extent whatever happens
      if (hs[h] == H_LIVE) begin
        r.lv = 1'b1; r.ls = h_start[h]; r.le = h_last[h];
      end
      if (slot < 0) begin
        r.status = StOom;
        hs[h] = H_ABSENT;
      end else begin
        s = fl_start[slot];
        if (best_len > size) fl_start[slot] = AddrBits'(s + size);
        else fl_vld[slot] = 1'b0;
        hs[h] = H_LIVE;
        h_start[h] = AddrBits'(s);
        h_last[h]  = AddrBits'(s + size - 1);
        r.bstart = AddrBits'(s);
      end
    end else if (hs[h] == H_LIVE) begin
      for (int i = 0; i < FreeSlots; i++)
        if (!fl_vld[i] && slot < 0) slot = i;
      if (slot < 0) r.status = StFull;
      else begin
        fl_vld[slot] = 1'b1; fl_start[slot] = h_start[h]; fl_last[slot] = h_last[h];
        hs[h] = H_FREED;
      end
    end else if (hs[h] == H_FREED) r.status = StDouble;
    else r.status = StInvalid;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fails_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t r;
    if (!rst_ni) begin
      placement = 2'd0;
      init_heap(17'd65536);
      expected_replies.delete();
      fails_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxMode) placement = cfg_data_i[1:0];
        else init_heap(cfg_data_i);
      end
      if (req_valid_i && req_ready_i) begin
        predict_allocation(kind_i, handle_id_i, request_size_i, r);
        expected_replies.insert(expected_replies.size(), r);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_replies.size() == 0) report("unexpected reply, status", status_i, -1);
        else begin
          r = expected_replies.pop_front();
          if (status_i !== r.status)      report("status", status_i, r.status);
          if (block_start_i !== r.bstart) report("block_start", block_start_i, r.bstart);
          if (leak_valid_i !== r.lv)      report("leak_valid", leak_valid_i, r.lv);
          if (leak_start_i !== r.ls)      report("leak_start", leak_start_i, r.ls);
          if (leak_end_i !== r.le)        report("leak_end", leak_end_i, r.le);
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives requests, settings and reply back-pressure, gives the verdict.
module tb_top;
  import fsha_pkg::*;

  localparam logic       KindFree    = ~KindAlloc;
  localparam logic [1:0] ModeFirst   = 2'd0;
  localparam logic [1:0] ModeSpare   = 2'd3;   // unused encoding, behaves as first fit
  localparam int         SettleCyc   = FreeSlots + 12; // one full slot sweep plus margin
  localparam int         IdleLimit   = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic        kind_i = 1'b0;
  logic [5:0]  handle_id_i = '0;
  logic [16:0] request_size_i = '0;
  logic        rsp_valid_o;
  logic        rsp_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] block_start_o;
  logic        leak_valid_o;
  logic [15:0] leak_start_o;
  logic [15:0] leak_end_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;

  int fails, pending, idle_cycles;
  bit quiet;  // when set, neither side inserts gaps

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fit_strategy_heap_allocator_unit u_dut (.*);

  fsha_alloc_checker u_chk (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_i(req_ready_o), .kind_i, .handle_id_i,
    .request_size_i, .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .status_i(status_o),
    .block_start_i(block_start_o), .leak_valid_i(leak_valid_o),
    .leak_start_i(leak_start_o), .leak_end_i(leak_end_o), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fails_o(fails), .pending_o(pending)
  );

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Watchdog: any cycle without a transaction on either channel counts.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reply side: a random stall before each transaction is taken.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rsp_valid_o && rsp_ready_i));
    end
  end

  // One request transaction; valid is dropped only when a gap follows.
  task automatic send(input logic kind, input logic [5:0] h, input logic [16:0] size);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i    <= 1'b1;
    kind_i         <= kind;
    handle_id_i    <= h;
    request_size_i <= size;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  // Block goes idle: every reply back, then one sweep's worth of cycles.
  // The first edge lets the checker log the last request before pending is read.
  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [16:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    logic [5:0]  h;
    logic [16:0] size;
    int          pick;
    h = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 70)      size = 17'($urandom_range(1, 64));
    else if (pick < 90) size = 17'($urandom_range(65, 4096));
    else if (pick < 97) size = 17'($urandom_range(4097, 131071));
    else                size = '0;
    send(($urandom_range(0, 99) < 55) ? KindAlloc : KindFree, h, size);
  endtask

  initial begin
    logic [16:0] words;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, first fit over the full space.
    send(KindFree,  6'd0,  17'd5);        // free of an absent handle
    send(KindAlloc, 6'd0,  17'd0);        // zero size runs out of memory
    send(KindAlloc, 6'd0,  17'd100);
    send(KindAlloc, 6'd0,  17'd50);       // re-allocate live handle: leak
    send(KindFree,  6'd0,  17'd1);
    send(KindFree,  6'd0,  17'd1);        // double free
    send(KindAlloc, 6'd0,  17'd10);       // freed handle reused, no leak
    send(KindAlloc, 6'd63, 17'h1FFFF);    // far too big
    send(KindAlloc, 6'd0,  17'd65536);    // out of memory on a live handle
    send(KindFree,  6'd0,  17'd1);        // now absent
    send(KindAlloc, 6'd63, 17'd65376);
    drain();

    // Smallest heap, best fit.
    write_reg(CfgIdxMode, {15'd0, ModeBest});
    write_reg(CfgIdxWords, 17'd1);
    send(KindAlloc, 6'd1, 17'd1);
    send(KindAlloc, 6'd2, 17'd1);
    drain();
    // Empty heap, then an oversized one that saturates.
    write_reg(CfgIdxWords, 17'd0);
    send(KindAlloc, 6'd3, 17'd1);
    drain();
    write_reg(CfgIdxMode, {15'd0, ModeSpare});
    write_reg(CfgIdxWords, 17'h1FFFF);
    send(KindAlloc, 6'd4, 17'd65536);
    send(KindFree,  6'd4, 17'd1);
    send(KindAlloc, 6'd5, 17'd3);
    drain();

    // Worst fit with unit allocations fills the free list, then a free is refused.
    write_reg(CfgIdxMode, {15'd0, ModeWorst});
    write_reg(CfgIdxWords, 17'd65536);
    quiet = 1'b1;
    for (int i = 0; i < FreeSlots + 2; i++) begin
      send(KindAlloc, 6'd7, 17'd1);
      send(KindFree,  6'd7, 17'd1);
    end
    send(KindAlloc, 6'd8, 17'd1);
    send(KindFree,  6'd8, 17'd1);         // free list full
    quiet = 1'b0;
    drain();

    // Random phases, each under fresh settings.
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 3))
        0:       words = 17'd65536;
        1:       words = 17'($urandom_range(1, 4096));
        2:       words = 17'($urandom_range(16, 256));
        default: words = 17'h1FFFF;
      endcase
      write_reg(CfgIdxMode, {15'd0, 2'($urandom_range(0, 3))});
      write_reg(CfgIdxWords, words);
      for (int n = 0; n < 180; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        random_item();
      end
      quiet = 1'b0;
      drain();
    end
    write_reg(CfgIdxMode, {15'd0, ModeFirst});

    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
hdl/fsha_pkg.sv
hdl/fsha_free_list.sv
hdl/fit_strategy_heap_allocator_unit.sv
tb/fsha_alloc_checker.sv
tb/tb_top.sv
